>>> rtl/dcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types and constants for the disk command block processor.
// ----------------------------------------------------------------------------
package dcb_pkg;

  localparam int DRIVE_COUNT_DEF = 4;

  localparam logic [5:0] ACT_GLOBAL   = 6'd2;
  localparam logic [5:0] ACT_SPECIFY  = 6'd3;
  localparam logic [5:0] ACT_HOME     = 6'd5;
  localparam logic [5:0] ACT_SEEK     = 6'd6;
  localparam logic [5:0] ACT_RDHDR    = 6'd7;
  localparam logic [5:0] ACT_RDWR     = 6'd8;
  localparam logic [5:0] ACT_FORMAT   = 6'd10;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_SEEK_TMO  = 2'd2;

  localparam logic [2:0] XK_NONE   = 3'd0;
  localparam logic [2:0] XK_READ   = 3'd1;
  localparam logic [2:0] XK_WRITE  = 3'd2;
  localparam logic [2:0] XK_FILL   = 3'd3;
  localparam logic [2:0] XK_HEADER = 3'd4;

  localparam logic [7:0]  MODE_ABS      = 8'hFF;
  localparam logic [23:0] LINK_RESET    = 24'h000050;

  // Per-drive geometry record, one memory word
  typedef struct packed {
    logic [15:0] sbytes;
    logic [15:0] spt;
    logic [15:0] heads;
    logic [15:0] tracks;
    logic [15:0] reserved;
    logic [15:0] pos;
  } geom_t;

  localparam geom_t GEOM_RESET = '{sbytes: 16'd1024, spt: 16'd9, heads: 16'd4,
                                   tracks: 16'd512, reserved: 16'd0, pos: 16'd5};

  typedef struct packed {
    logic [5:0]  action;
    logic        irq;
    logic [1:0]  drive;
    logic [7:0]  argb;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
    logic [15:0] wd;
    logic [15:0] we;
    logic [23:0] daddr;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] blk;
    logic        irq;
    logic [2:0]  kind;
    logic [31:0] off;
    logic [31:0] cnt;
    logic [23:0] maddr;
    logic [7:0]  fill;
    logic [15:0] htrk;
    logic [15:0] nsec;
    logic [15:0] ntrk;
    logic [23:0] ndata;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/dcb_geom_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcb_geom_mem
// Per-drive geometry memory, registered read, valid bit per entry.
// ----------------------------------------------------------------------------
module dcb_geom_mem #(
  parameter int DRIVE_COUNT = dcb_pkg::DRIVE_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] raddr,
  output dcb_pkg::geom_t rdata,
  input  wire logic we,
  input  wire logic [1:0] waddr,
  input  dcb_pkg::geom_t wdata
);
  import dcb_pkg::*;

  geom_t mem [DRIVE_COUNT];
  logic [DRIVE_COUNT-1:0] vld;
  geom_t rd;
  logic  rd_vld;

  always_ff @(posedge clk) begin
    if (we && 32'(waddr) < DRIVE_COUNT) mem[waddr] <= wdata;
    if (32'(raddr) < DRIVE_COUNT) begin
      rd     <= mem[raddr];
      rd_vld <= vld[raddr];
    end else begin
      rd     <= GEOM_RESET;
      rd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we && 32'(waddr) < DRIVE_COUNT) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd : GEOM_RESET;
endmodule
`default_nettype wire

>>> rtl/dcb_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcb_exec
// Command sequencer: reads geometry, multiplies in the M1 and M2 states, performs
// the sector wrap by restoring division, writes the record back.
// ----------------------------------------------------------------------------
module dcb_exec (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  dcb_pkg::cmd_t cmd,
  input  wire logic drv_ok,
  input  wire logic [23:0] blk,
  output logic busy,
  output logic done,
  output dcb_pkg::res_t res,
  output logic [1:0] raddr,
  input  dcb_pkg::geom_t rdata,
  output logic gwe,
  output dcb_pkg::geom_t gwdata
);
  import dcb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_M1   = 7'b0000100,
    S_M2   = 7'b0001000,
    S_M3   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } st_t;

  st_t state;
  cmd_t c;
  logic ok;
  geom_t g;
  logic [7:0] mode;
  logic [31:0] tlen, len, p1, p2;
  logic [15:0] sum, rem;
  logic [4:0] bitn;
  logic [17:0] trial;

  // read is issued on the accepting edge so the record is ready in S_READ
  assign raddr = (state == S_IDLE && start) ? cmd.drive : c.drive;
  assign busy  = (state != S_IDLE);
  assign trial = {1'b0, rem, sum[15]} - {2'b00, g.spt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      gwe   <= 1'b0;
      mode  <= 8'd0;
    end else begin
      done <= 1'b0;
      gwe  <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          c <= cmd; ok <= drv_ok; res.blk <= blk;
          state <= S_READ;
        end
        S_READ: begin
          g <= rdata;
          state <= S_M1;
        end
        S_M1: begin
          tlen <= 32'(g.spt) * 32'(g.sbytes);
          len  <= 32'(c.wc) * 32'(g.sbytes);
          p1   <= 32'(g.pos) * 32'(g.heads);
          sum  <= c.wa + c.wc;
          state <= S_M2;
        end
        S_M2: begin
          // read/write: offset terms; format: (track*heads + head) * tlen
          if (c.action == ACT_RDWR) begin
            p1 <= 32'(c.wb) * tlen;
            p2 <= 32'(c.wa) * 32'(g.sbytes);
          end else begin
            p1 <= (p1 + 32'(c.wb)) * tlen;
          end
          rem <= '0; bitn <= 5'd16;
          state <= S_M3;
        end
        S_M3: begin
          if (c.action == ACT_RDWR) p1 <= p1 + p2;
          state <= (ok && c.action == ACT_RDWR && mode != MODE_ABS &&
                    sum >= g.spt && g.spt != 16'd0) ? S_DIV : S_FIN;
        end
        S_DIV: begin
          // restoring remainder, one bit per cycle
          if (!trial[17]) rem <= trial[15:0];
          else rem <= {rem[14:0], sum[15]};
          sum  <= {sum[14:0], 1'b0};
          bitn <= bitn - 5'd1;
          if (bitn == 5'd1) state <= S_FIN;
        end
        S_FIN: begin
          res.status <= ST_OK; res.irq <= c.irq; res.kind <= XK_NONE;
          res.off <= '0; res.cnt <= '0; res.maddr <= '0; res.fill <= '0;
          res.htrk <= '0; res.nsec <= c.wa; res.ntrk <= c.wb;
          res.ndata <= c.daddr;
          gwdata <= g;
          if (!ok) begin
            res.status <= ST_NOT_READY;
          end else begin
            case (c.action)
              ACT_GLOBAL: mode <= c.argb;
              ACT_SPECIFY: begin
                gwdata <= '{sbytes: c.wa, spt: c.wb, heads: c.wc,
                            tracks: c.wd, reserved: c.we, pos: g.pos};
                gwe <= 1'b1;
              end
              ACT_HOME: begin
                gwdata.pos <= '0; gwe <= 1'b1;
              end
              ACT_SEEK: begin
                gwe <= 1'b1;
                if (c.wa >= g.tracks) begin
                  gwdata.pos <= g.tracks - 16'd1;
                  res.status <= ST_SEEK_TMO;
                end else gwdata.pos <= c.wa;
              end
              ACT_RDHDR: begin
                res.kind <= XK_HEADER; res.maddr <= c.daddr; res.cnt <= 32'd4;
                res.htrk <= g.pos;
              end
              ACT_RDWR: if (mode != MODE_ABS) begin
                res.kind <= (c.argb == 8'd1) ? XK_READ : XK_WRITE;
                res.off <= p1; res.cnt <= len; res.maddr <= c.daddr;
                res.ndata <= c.daddr + len[23:0];
                if ((c.wa + c.wc) >= g.spt) begin
                  res.nsec <= (g.spt != 16'd0) ? rem : c.wa + c.wc;
                  res.ntrk <= c.wb + 16'd1;
                end else begin
                  res.nsec <= c.wa + c.wc;
                end
              end
              ACT_FORMAT: begin
                res.kind <= XK_FILL; res.off <= p1; res.cnt <= tlen;
                res.fill <= c.wa[7:0];
              end
              default: ;
            endcase
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN) else $error("done without finish");
  a_we_with_done: assert property (@(posedge clk) disable iff (rst)
    gwe |-> done) else $error("write-back outside finish");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> busy) else $error("start lost");
endmodule
`default_nettype wire

>>> rtl/disk_command_block_processor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disk_command_block_processor
// Executes fetched disk command blocks against per-drive geometry.
// ----------------------------------------------------------------------------
// Sequence: geometry read, states M1 to M3, then finish; a read/write that wraps
//   the sector adds a bit-serial remainder state first. One request at a time;
//   a full output register holds off the next one.
// Reset: geometry valid bits cleared (entries read as defaults), link 0x50,
//   mode 0, ready mask 0.
module disk_command_block_processor #(
  parameter int DRIVE_COUNT = dcb_pkg::DRIVE_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [3:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [5:0] action,
  input  wire logic request_irq,
  input  wire logic [1:0] drive,
  input  wire logic [7:0] arg_byte,
  input  wire logic [15:0] word_a,
  input  wire logic [15:0] word_b,
  input  wire logic [15:0] word_c,
  input  wire logic [15:0] word_d,
  input  wire logic [15:0] word_e,
  input  wire logic [23:0] data_addr,
  input  wire logic [23:0] link_addr,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic [23:0] block_addr,
  output logic raise_irq,
  output logic [2:0] xfer_kind,
  output logic [31:0] byte_offset,
  output logic [31:0] byte_count,
  output logic [23:0] mem_addr,
  output logic [7:0] fill_byte,
  output logic [15:0] header_track,
  output logic [15:0] next_sector,
  output logic [15:0] next_track,
  output logic [23:0] next_data_addr
);
  import dcb_pkg::*;

  logic [3:0] mask;
  logic [23:0] link;
  logic busy, done, gwe, start, drv_ok;
  logic [1:0] raddr;
  geom_t rdata, gwdata;
  res_t res, oreg;
  cmd_t cmd;
  logic pend;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !done && !pend;
  assign start     = in_valid && in_ready;
  assign drv_ok    = (32'(drive) < DRIVE_COUNT) && mask[drive];
  assign cmd = '{action: action, irq: request_irq, drive: drive, argb: arg_byte,
                 wa: word_a, wb: word_b, wc: word_c, wd: word_d, we: word_e,
                 daddr: data_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      link <= LINK_RESET;
    end else begin
      if (cfg_valid) mask <= cfg_data;
      if (start) link <= link_addr;
    end
  end

  dcb_geom_mem #(.DRIVE_COUNT(DRIVE_COUNT)) u_mem (
    .clk(clk), .rst(rst), .raddr(raddr), .rdata(rdata),
    .we(gwe), .waddr(raddr), .wdata(gwdata)
  );

  dcb_exec u_exec (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .drv_ok(drv_ok), .blk(link),
    .busy(busy), .done(done), .res(res), .raddr(raddr), .rdata(rdata),
    .gwe(gwe), .gwdata(gwdata)
  );

  // output register; core waits in idle while it is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else if ((pend || done) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      pend <= 1'b0;
      oreg <= res;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (done) pend <= 1'b1;
    end
  end

  assign status = oreg.status;         assign block_addr = oreg.blk;
  assign raise_irq = oreg.irq;         assign xfer_kind = oreg.kind;
  assign byte_offset = oreg.off;       assign byte_count = oreg.cnt;
  assign mem_addr = oreg.maddr;        assign fill_byte = oreg.fill;
  assign header_track = oreg.htrk;     assign next_sector = oreg.nsec;
  assign next_track = oreg.ntrk;       assign next_data_addr = oreg.ndata;
endmodule
`default_nettype wire
